### design/dos_timestamp_converter_defines.svh
// ============================================================================
// DOS timestamp converter: assertion macros
// Shared concurrent assertion forms for the converter design files.
// ============================================================================
`ifndef DOS_TIMESTAMP_CONVERTER_DEFINES_SVH
`define DOS_TIMESTAMP_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DTC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define DTC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/dtc_pkg.sv
// ============================================================================
// dtc_pkg
// Shared constants, calendar helpers and control types for the converter.
// ============================================================================
package dtc_pkg;

    // Calendar constants
    localparam int unsigned EPOCH_TO_1980_DAYS = 3652;
    localparam int unsigned SECS_PER_DAY       = 86400;
    localparam int unsigned SECS_PER_HOUR      = 3600;
    localparam int unsigned SECS_PER_MIN       = 60;
    localparam int unsigned DAYS_PER_YEAR      = 365;
    localparam longint      FIRST_LOCAL_SECS   = 315532800;
    localparam int unsigned YEAR_2100_INDEX    = 120;
    localparam int unsigned LAST_YEAR_INDEX    = 127;

    // Internal pipeline stages between input and output registers
    localparam int unsigned NUM_STAGES = 4;

    // Day split: seconds >> 7, then divide by 675 (86400 = 675 * 128)
    localparam int unsigned DAY_LO_BITS      = 7;
    localparam int unsigned DAY_Q_DIV        = SECS_PER_DAY >> DAY_LO_BITS;
    localparam int unsigned DAY_RECIP_SHIFT  = 36;
    localparam longint unsigned DAY_RECIP =
        ((64'd1 << DAY_RECIP_SHIFT) + DAY_Q_DIV - 1) / DAY_Q_DIV;

    // Year estimate: days / 365 for 16-bit day counts
    localparam int unsigned YEAR_RECIP_SHIFT = 25;
    localparam longint unsigned YEAR_RECIP =
        ((64'd1 << YEAR_RECIP_SHIFT) + DAYS_PER_YEAR - 1) / DAYS_PER_YEAR;

    // Seconds of day / 60 and / 3600 for values below one day
    localparam int unsigned MIN_RECIP_SHIFT  = 23;
    localparam longint unsigned MIN_RECIP =
        ((64'd1 << MIN_RECIP_SHIFT) + SECS_PER_MIN - 1) / SECS_PER_MIN;
    localparam int unsigned HOUR_RECIP_SHIFT = 29;
    localparam longint unsigned HOUR_RECIP =
        ((64'd1 << HOUR_RECIP_SHIFT) + SECS_PER_HOUR - 1) / SECS_PER_HOUR;

    // Cumulative days before each month; codes past December start at zero
    localparam logic [8:0] MONTH_START [16] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181, 9'd212,
        9'd243, 9'd273, 9'd304, 9'd334, 9'd0,   9'd0,   9'd0,   9'd0
    };

    typedef logic signed [17:0] offset_secs_t;

    // Pipeline load enables and status from the control unit
    typedef struct packed {
        logic                  in_load;
        logic [NUM_STAGES-1:0] stage_load;
        logic                  out_load;
        logic                  busy;
    } dtc_ctrl_t;

    // Leap year by index from 1980; 2100 is not a leap year
    function automatic logic is_leap(input logic [7:0] y);
        return (y[1:0] == 2'b00) && (y != 8'(YEAR_2100_INDEX));
    endfunction

    // Days from 1980-01-01 to the first of year index y
    function automatic logic [15:0] days_before_year(input logic [7:0] y);
        logic [15:0] d;
        d = 16'(y) * 16'(DAYS_PER_YEAR) + 16'((9'(y) + 9'd3) >> 2);
        if (y > 8'(YEAR_2100_INDEX))
        begin
            d = d - 16'd1;
        end
        return d;
    endfunction

endpackage

### design/dtc_pipe_ctrl.sv
// ============================================================================
// dtc_pipe_ctrl
// Valid tracking, per-stage load enables and command bit for the pipeline.
// ============================================================================
module dtc_pipe_ctrl
    import dtc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      command,
    input  logic      out_ready,
    output logic      in_ready,
    output logic      out_valid,
    output logic      stage_cmd,
    output dtc_ctrl_t ctrl
);

    localparam int unsigned LAST = NUM_STAGES + 1;

    logic [LAST:0]   valid_reg, valid_next;
    logic [LAST:0]   load;
    logic [LAST-1:0] cmd_reg, cmd_next;

    // A stage loads when it is empty or its content moves on
    always_comb
    begin
        load[LAST] = !valid_reg[LAST] || out_ready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    // Next valid and command bits
    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (load[0])
        begin
            valid_next[0] = in_valid;
            cmd_next[0]   = command;
        end
        for (int i = 1; i <= LAST; i++)
        begin
            if (load[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
        for (int i = 1; i < LAST; i++)
        begin
            if (load[i])
            begin
                cmd_next[i] = cmd_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            cmd_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cmd_reg   <= cmd_next;
        end
    end

    assign in_ready        = load[0];
    assign out_valid       = valid_reg[LAST];
    assign stage_cmd       = cmd_reg[LAST-1];
    assign ctrl.in_load    = load[0];
    assign ctrl.stage_load = load[LAST-1:1];
    assign ctrl.out_load   = load[LAST];
    assign ctrl.busy       = |valid_reg;

endmodule

### design/dtc_dos2unix.sv
// ============================================================================
// dtc_dos2unix
// DOS time/date words to UTC seconds: day count, then scale and offset.
// ============================================================================
module dtc_dos2unix
    import dtc_pkg::*;
(
    input  logic         clk,
    input  dtc_ctrl_t    ctrl,
    input  logic [15:0]  dos_time,
    input  logic [15:0]  dos_date,
    input  offset_secs_t tz_secs,
    output logic [32:0]  unix_secs
);

    logic [7:0]  year;
    logic [3:0]  mfield, idx;
    logic        leap_adj;
    logic [15:0] days_next, days_reg;
    logic [16:0] tsec_next, tsec_reg;
    logic [32:0] day_secs;
    logic signed [34:0] sum;
    logic [32:0] secs_next, secs2_reg, secs3_reg, secs4_reg;

    // Stage 1: day count since 1970 and seconds of day
    always_comb
    begin
        year      = {1'b0, dos_date[15:9]};
        mfield    = dos_date[8:5];
        idx       = (mfield == 4'd0) ? 4'd0 : mfield - 4'd1;
        leap_adj  = (idx >= 4'd2) && is_leap(year);
        days_next = 16'(EPOCH_TO_1980_DAYS) + days_before_year(year)
                  + 16'(MONTH_START[idx]) + 16'(dos_date[4:0]) + 16'(leap_adj)
                  - 16'd1;
        tsec_next = 17'({dos_time[4:0], 1'b0})
                  + 17'(dos_time[10:5]) * 17'(SECS_PER_MIN)
                  + 17'(dos_time[15:11]) * 17'(SECS_PER_HOUR);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.stage_load[0])
        begin
            days_reg <= days_next;
            tsec_reg <= tsec_next;
        end
    end

    // Stage 2: scale days, add time of day and zone offset, floor at zero
    always_comb
    begin
        day_secs  = 33'(days_reg) * 33'(SECS_PER_DAY);
        sum       = $signed({2'b00, day_secs}) + $signed({18'b0, tsec_reg})
                  + 35'(tz_secs);
        secs_next = sum[34] ? '0 : sum[32:0];
    end

    // Stages 2 to 4: result, then delay to match the other direction
    always_ff @(posedge clk)
    begin
        if (ctrl.stage_load[1])
        begin
            secs2_reg <= secs_next;
        end
        if (ctrl.stage_load[2])
        begin
            secs3_reg <= secs2_reg;
        end
        if (ctrl.stage_load[3])
        begin
            secs4_reg <= secs3_reg;
        end
    end

    assign unix_secs = secs4_reg;

endmodule

### design/dtc_unix2dos.sv
// ============================================================================
// dtc_unix2dos
// UTC seconds to DOS words: local shift, day split, year and month search.
// ============================================================================
module dtc_unix2dos
    import dtc_pkg::*;
(
    input  logic         clk,
    input  dtc_ctrl_t    ctrl,
    input  logic [31:0]  unix_seconds,
    input  offset_secs_t tz_secs,
    output logic [15:0]  time_word,
    output logic [15:0]  date_word,
    output logic         range_err
);

    // Stage 1 signals
    logic signed [34:0] loc_secs;
    logic [32:0] loc_reg;
    logic        low1_reg;
    // Stage 2 signals
    logic [52:0] day_prod;
    logic [15:0] days_next, days2_reg;
    logic [25:0] q2_reg;
    logic [6:0]  lo2_reg;
    logic        low2_reg;
    // Stage 3 signals
    logic [9:0]  r_next;
    logic [15:0] d_next, d3_reg;
    logic [32:0] yr_prod;
    logic [16:0] rem3_reg;
    logic [7:0]  y03_reg;
    logic        low3_reg;
    // Stage 4 signals
    logic [15:0] dby0;
    logic        over;
    logic [7:0]  yprev, y_next, y4_reg;
    logic [8:0]  doy_next, doy4_reg;
    logic [34:0] min_prod, hour_prod;
    logic [10:0] tmin4_reg;
    logic [4:0]  hr4_reg;
    logic [16:0] rem4_reg;
    logic        low4_reg;
    // Final logic
    logic [5:0]  sec, minute;
    logic        leap;
    logic [8:0]  adj;
    logic [3:0]  month;
    logic [4:0]  mday;

    // Stage 1: shift to local time, flag times before 1980
    assign loc_secs = $signed({3'b000, unix_seconds}) - 35'(tz_secs);

    always_ff @(posedge clk)
    begin
        if (ctrl.stage_load[0])
        begin
            loc_reg  <= loc_secs[32:0];
            low1_reg <= loc_secs < $signed(35'(FIRST_LOCAL_SECS));
        end
    end

    // Stage 2: day number by reciprocal of 675 on seconds >> 7
    always_comb
    begin
        day_prod  = 53'(loc_reg[32:DAY_LO_BITS]) * 53'(DAY_RECIP);
        days_next = 16'(day_prod >> DAY_RECIP_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.stage_load[1])
        begin
            days2_reg <= days_next;
            q2_reg    <= loc_reg[32:DAY_LO_BITS];
            lo2_reg   <= loc_reg[DAY_LO_BITS-1:0];
            low2_reg  <= low1_reg;
        end
    end

    // Stage 3: seconds of day, days since 1980, year estimate
    always_comb
    begin
        r_next  = 10'(q2_reg - 26'(days2_reg) * 26'(DAY_Q_DIV));
        d_next  = days2_reg - 16'(EPOCH_TO_1980_DAYS);
        yr_prod = 33'(d_next) * 33'(YEAR_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.stage_load[2])
        begin
            rem3_reg <= {r_next, lo2_reg};
            d3_reg   <= d_next;
            y03_reg  <= 8'(yr_prod >> YEAR_RECIP_SHIFT);
            low3_reg <= low2_reg;
        end
    end

    // Stage 4: correct year, day of year; minutes and hours of day
    always_comb
    begin
        dby0      = days_before_year(y03_reg);
        over      = dby0 > d3_reg;
        yprev     = y03_reg - 8'd1;
        y_next    = over ? yprev : y03_reg;
        doy_next  = 9'(17'(d3_reg)
                  + (over ? 17'(DAYS_PER_YEAR) + 17'(is_leap(yprev)) : 17'd0)
                  - 17'(dby0));
        min_prod  = 35'(rem3_reg) * 35'(MIN_RECIP);
        hour_prod = 35'(rem3_reg) * 35'(HOUR_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.stage_load[3])
        begin
            y4_reg    <= y_next;
            doy4_reg  <= doy_next;
            tmin4_reg <= 11'(min_prod >> MIN_RECIP_SHIFT);
            hr4_reg   <= 5'(hour_prod >> HOUR_RECIP_SHIFT);
            rem4_reg  <= rem3_reg;
            low4_reg  <= low3_reg;
        end
    end

    // Final: time fields, month search, range check and packing
    always_comb
    begin
        sec    = 6'(rem4_reg - 17'(tmin4_reg) * 17'(SECS_PER_MIN));
        minute = 6'(tmin4_reg - 11'(hr4_reg) * 11'(SECS_PER_MIN));
        leap   = is_leap(y4_reg);
        adj    = (leap && doy4_reg > 9'd59) ? doy4_reg - 9'd1 : doy4_reg;
        month  = 4'd1;
        for (int i = 1; i < 12; i++)
        begin
            if (MONTH_START[i] <= adj)
            begin
                month = month + 4'd1;
            end
        end
        mday = 5'(adj - MONTH_START[month - 4'd1] + 9'd1);
        // 29 February
        if (leap && doy4_reg == 9'd59)
        begin
            month = 4'd2;
            mday  = 5'd29;
        end
        range_err = low4_reg || (y4_reg > 8'(LAST_YEAR_INDEX));
        time_word = range_err ? '0 : {hr4_reg, minute, sec[5:1]};
        date_word = range_err ? '0 : {y4_reg[6:0], month, mday};
    end

endmodule

### design/dos_timestamp_converter.sv
// ============================================================================
// dos_timestamp_converter
// Converts DOS time/date words to UTC seconds and back, one item per cycle while out_ready is high.
// ============================================================================
//
//  Channel  Handshake             Payload
//  -------  --------------------  --------------------------------------------
//  cfg      cfg_valid/cfg_ready   cfg_data: zone offset, minutes west (signed)
//  in       in_valid/in_ready     command, dos_time, dos_date, unix_seconds
//  out      out_valid/out_ready   unix_seconds_out, dos_time_out, dos_date_out,
//                                 out_of_range
//
//  The input register loads at acceptance, then four arithmetic stages and the
//  output register carry each transaction through to out_valid.
//  Throughput is one transaction per cycle while out_ready stays high.
//  Each stage carries its own valid bit and loads when empty or draining, so
//  bubbles close up under an output stall. Reset clears valids and sets the
//  zone offset to zero; cfg_ready is always high.
//
`include "dos_timestamp_converter_defines.svh"

module dos_timestamp_converter
    import dtc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic signed [11:0] cfg_data,
    // input items
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic [15:0]        dos_time,
    input  logic [15:0]        dos_date,
    input  logic [31:0]        unix_seconds,
    // results
    output logic               out_valid,
    input  logic               out_ready,
    output logic [32:0]        unix_seconds_out,
    output logic [15:0]        dos_time_out,
    output logic [15:0]        dos_date_out,
    output logic               out_of_range
);

    dtc_ctrl_t          ctrl;
    logic               stage_cmd;
    logic signed [11:0] tz_offset_reg;
    offset_secs_t       tz_secs;
    logic [15:0]        dos_time_reg, dos_date_reg;
    logic [31:0]        unix_seconds_reg;
    logic [32:0]        d2u_secs;
    logic [15:0]        u2d_time, u2d_date;
    logic               u2d_err;
    logic [32:0]        unix_out_reg;
    logic [15:0]        time_out_reg, date_out_reg;
    logic               oor_out_reg;

    // Zone offset register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tz_offset_reg <= '0;
        end
        else if (cfg_valid)
        begin
            tz_offset_reg <= cfg_data;
        end
    end

    assign tz_secs = 18'(tz_offset_reg) * 18'sd60;

    // Pipeline control
    dtc_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .command   (command),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .stage_cmd (stage_cmd),
        .ctrl      (ctrl)
    );

    // Input register
    always_ff @(posedge clk)
    begin
        if (ctrl.in_load)
        begin
            dos_time_reg     <= dos_time;
            dos_date_reg     <= dos_date;
            unix_seconds_reg <= unix_seconds;
        end
    end

    // Both directions run on every transaction; command picks the result
    dtc_dos2unix u_d2u (
        .clk       (clk),
        .ctrl      (ctrl),
        .dos_time  (dos_time_reg),
        .dos_date  (dos_date_reg),
        .tz_secs   (tz_secs),
        .unix_secs (d2u_secs)
    );

    dtc_unix2dos u_u2d (
        .clk          (clk),
        .ctrl         (ctrl),
        .unix_seconds (unix_seconds_reg),
        .tz_secs      (tz_secs),
        .time_word    (u2d_time),
        .date_word    (u2d_date),
        .range_err    (u2d_err)
    );

    // Output register; unused fields are zero
    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            unix_out_reg <= stage_cmd ? '0 : d2u_secs;
            time_out_reg <= stage_cmd ? u2d_time : '0;
            date_out_reg <= stage_cmd ? u2d_date : '0;
            oor_out_reg  <= stage_cmd ? u2d_err : 1'b0;
        end
    end

    assign unix_seconds_out = unix_out_reg;
    assign dos_time_out     = time_out_reg;
    assign dos_date_out     = date_out_reg;
    assign out_of_range     = oor_out_reg;

    // Checks
    `DTC_ASSERT_IMP(a_ready_when_out_empty, clk, rst_n, !out_valid, in_ready,
        "input stalled while output register is empty")
    `DTC_ASSERT_IMP(a_oor_zero_words, clk, rst_n, out_valid && out_of_range,
        (dos_time_out == 16'd0) && (dos_date_out == 16'd0) && (unix_seconds_out == 33'd0),
        "out_of_range result carries nonzero fields")
    `DTC_ASSERT_IMP(a_one_direction, clk, rst_n, out_valid,
        (unix_seconds_out == 33'd0) || ((dos_time_out == 16'd0) && (dos_date_out == 16'd0)),
        "result carries both directions")
    `DTC_ASSERT_NXT(a_no_phantom_result, clk, rst_n, !ctrl.busy && !in_valid, !out_valid,
        "result appeared with empty pipeline")

endmodule
